// ===== rtl/wear_leveled_config_store_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the wear-leveled configuration store
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef WEAR_LEVELED_CONFIG_STORE_TOP_MACROS_SVH
`define WEAR_LEVELED_CONFIG_STORE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WLCS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("wlcs check failed");
`define WLCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wlcs check failed");
`else
`define WLCS_ASSERT(label, clk, rst, prop)
`define WLCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/wlcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Wear-leveled config store package
// Word types, function and status codes shared by the store's modules.
// ---------------------------------------------------------------------------
package wlcs_pkg;

  localparam logic [31:0] MAGIC_TOKEN   = 32'h434f4e46;
  localparam logic [31:0] BLANK_WORD    = 32'hffffffff;
  localparam logic [15:0] WB_MASK_RESET = 16'd15;
  localparam int          RESULT_CAP    = 32;

  // Function codes of an input word.
  localparam logic [2:0] FN_GET       = 3'd0;
  localparam logic [2:0] FN_SET       = 3'd1;
  localparam logic [2:0] FN_TICK      = 3'd2;
  localparam logic [2:0] FN_WIPE      = 3'd3;
  localparam logic [2:0] FN_LOAD_WORD = 3'd4;

  // Flash status codes.
  localparam logic [2:0] FS_IDLE      = 3'd0;
  localparam logic [2:0] FS_BUSY      = 3'd1;
  localparam logic [2:0] FS_LOAD_DONE = 3'd2;
  localparam logic [2:0] FS_LOAD_ERR  = 3'd3;
  localparam logic [2:0] FS_SAVE_DONE = 3'd4;
  localparam logic [2:0] FS_SAVE_ERR  = 3'd5;

  // Flash commands.
  localparam logic [1:0] CMD_NONE        = 2'd0;
  localparam logic [1:0] CMD_LOAD        = 2'd1;
  localparam logic [1:0] CMD_ERASE_WRITE = 2'd2;
  localparam logic [1:0] CMD_WRITE       = 2'd3;

  // Events.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_LOADED  = 2'd1;
  localparam logic [1:0] EV_CLEARED = 2'd2;

  typedef enum logic [2:0] {
    MODE_NOT_LOADED = 3'd0,
    MODE_LOADED     = 3'd1,
    MODE_LOADING    = 3'd2,
    MODE_SAVING     = 3'd3,
    MODE_ERASING    = 3'd4
  } io_mode_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  addr;
    logic [31:0] value;
    logic [9:0]  word_index;
    logic [2:0]  flash_state;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  flash_cmd;
    logic [9:0]  flash_word_addr;
    logic [31:0] data_word;
    logic        last;
    logic [1:0]  event_res;
    logic [2:0]  store_state;
    logic        dirty_flag;
    logic        refused;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } cfg_ram_ctl_t;

endpackage

// ===== rtl/wlcs_cfg_ram.sv =====
// ---------------------------------------------------------------------------
// Config word RAM
// One write and one registered read port, with a valid bit per entry so
// that reset, and a clear bar the token entry, make entries read all ones.
// ---------------------------------------------------------------------------
module wlcs_cfg_ram #(
  parameter int NUM_ENTRIES = 32,
  parameter int TOKEN_POS   = 31,
  parameter int ADDR_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wlcs_pkg::cfg_ram_ctl_t ctl,
  input  logic [ADDR_W-1:0]     rd_addr,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [31:0]           wr_data,
  output logic [31:0]           rd_data
);
  import wlcs_pkg::*;

  // The clear keeps only the token entry.
  localparam logic [NUM_ENTRIES-1:0] KEEP_MASK =
    {{(NUM_ENTRIES-1){1'b0}}, 1'b1} << TOKEN_POS;

  logic [31:0]            mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid;
  logic [31:0]            rd_word;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= valid & KEEP_MASK;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_valid ? rd_word : BLANK_WORD;

endmodule

// ===== rtl/wear_leveled_config_store_top.sv =====
// ---------------------------------------------------------------------------
// Wear-leveled configuration store
// Keeps config words in RAM and saves them slot by slot into a flash sector.
// ---------------------------------------------------------------------------
// Get, set, load-word and plain tick words are accepted, then executed in
// EXEC against the registered RAM read once the output is free; a new word
// is taken only back in IDLE. A writeback or wipe does one RAM read and one
// sector write per word of the run. A load search probes slots from the last
// down, copies the slot it finds or clears the RAM, then emits the event word.
// Reset is synchronous; config entries read as all ones and no sweep is run.
`include "wear_leveled_config_store_top_macros.svh"

module wear_leveled_config_store_top #(
  parameter int NUM_ENTRIES  = 32,
  parameter int SECTOR_WORDS = 1024,
  parameter int TOKEN_INDEX  = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wlcs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wlcs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import wlcs_pkg::*;

  // The sector holds NUM_SLOTS slots of NUM_ENTRIES words each. The token
  // entry falls back to the last entry when TOKEN_INDEX does not fit.
  localparam int NUM_SLOTS = SECTOR_WORDS / NUM_ENTRIES;
  localparam int TOKEN_POS = (TOKEN_INDEX < NUM_ENTRIES) ? TOKEN_INDEX : NUM_ENTRIES - 1;
  localparam int CIW       = $clog2(NUM_ENTRIES);
  localparam int SAW       = $clog2(SECTOR_WORDS);
  localparam int SPW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RUN_EMIT  = (NUM_ENTRIES < RESULT_CAP) ? NUM_ENTRIES : RESULT_CAP;
  localparam logic [SAW-1:0] LAST_BASE = SAW'((NUM_SLOTS - 1) * NUM_ENTRIES);

  // Sequencer states. EXEC handles every word once; the RUN, SRCH and
  // COPY pairs walk the RAMs with one read and one use per step.
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_EXEC     = 9'b000000010,
    S_RUN_RD   = 9'b000000100,
    S_RUN_WR   = 9'b000001000,
    S_SRCH_RD  = 9'b000010000,
    S_SRCH_CMP = 9'b000100000,
    S_COPY_RD  = 9'b001000000,
    S_COPY_WR  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t         state, state_next;
  in_item_t       item;
  io_mode_t       io_mode, io_mode_next;
  logic           dirty, dirty_next;
  logic [SPW-1:0] slot, slot_next;
  logic [15:0]    tick_count, tick_count_next;
  logic [15:0]    wb_mask;

  // Walk registers shared by the writeback, wipe, search and copy.
  logic [CIW-1:0] j, j_next;
  logic [1:0]     run_cmd, run_cmd_next;
  logic [9:0]     run_base, run_base_next;
  logic           run_blank, run_blank_next;
  logic [SAW-1:0] srch_base, srch_base_next;
  logic [SPW-1:0] srch_slot, srch_slot_next;
  logic           found, found_next;

  // Config RAM port.
  cfg_ram_ctl_t   cfg_ctl;
  logic [CIW-1:0] cfg_rd_addr;
  logic [CIW-1:0] cfg_wr_addr;
  logic [31:0]    cfg_wr_data;
  logic [31:0]    cfg_rd_data;

  // Sector buffer port. Its reset is undefined, so it has no valid bits.
  logic [31:0]    sector_mem [SECTOR_WORDS];
  logic           sec_we;
  logic [SAW-1:0] sec_waddr;
  logic [31:0]    sec_wdata;
  logic [SAW-1:0] sec_raddr;
  logic [31:0]    sec_rd;

  // Result path.
  logic      out_free;
  logic      emit;
  out_item_t res;

  // Address decode of the held word.
  logic           addr_ok;
  logic [16:0]    widx_wide;
  logic           widx_ok;
  logic [SPW:0]   slot_inc;
  logic           slot_wrap;
  logic [16:0]    inc_base_full;
  logic [31:0]    run_word;
  logic           word_shown;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign addr_ok       = item.addr < 8'(NUM_ENTRIES);
  assign widx_wide     = 17'(item.word_index);
  assign widx_ok       = widx_wide < 17'(SECTOR_WORDS);
  assign slot_inc      = {1'b0, slot} + (SPW+1)'(1);
  assign slot_wrap     = slot_inc >= (SPW+1)'(NUM_SLOTS);
  assign inc_base_full = 17'(slot_inc) * 17'(NUM_ENTRIES);
  assign run_word      = run_blank ? BLANK_WORD : cfg_rd_data;
  assign word_shown    = 7'(j) < 7'(RESULT_CAP);

  wlcs_cfg_ram #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .TOKEN_POS   (TOKEN_POS),
    .ADDR_W      (CIW)
  ) u_cfg_ram (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cfg_ctl),
    .rd_addr (cfg_rd_addr),
    .wr_addr (cfg_wr_addr),
    .wr_data (cfg_wr_data),
    .rd_data (cfg_rd_data)
  );

  // The sector buffer is read every cycle; the data is used in the cycle after
  // the address was presented.
  always_ff @(posedge clk) begin
    if (sec_we) begin
      sector_mem[sec_waddr] <= sec_wdata;
    end
    sec_rd <= sector_mem[sec_raddr];
  end

  always_comb begin
    logic single;
    single          = 1'b0;
    state_next      = state;
    io_mode_next    = io_mode;
    dirty_next      = dirty;
    slot_next       = slot;
    tick_count_next = tick_count;
    j_next          = j;
    run_cmd_next    = run_cmd;
    run_base_next   = run_base;
    run_blank_next  = run_blank;
    srch_base_next  = srch_base;
    srch_slot_next  = srch_slot;
    found_next      = found;
    emit            = 1'b0;
    res             = '0;
    cfg_ctl         = '0;
    cfg_rd_addr     = in_data.addr[CIW-1:0];
    cfg_wr_addr     = item.addr[CIW-1:0];
    cfg_wr_data     = item.value;
    sec_we          = 1'b0;
    sec_waddr       = widx_wide[SAW-1:0];
    sec_wdata       = item.value;
    sec_raddr       = srch_base + SAW'(TOKEN_POS);

    unique case (state)
      S_IDLE: begin
        // The config read for a get or set starts as the word is taken.
        if (in_valid) begin
          cfg_ctl.rd_en = 1'b1;
          state_next    = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          single = 1'b1;
          unique case (item.func)
            FN_GET: begin
              res.read_value = addr_ok ? cfg_rd_data : 32'd0;
            end
            FN_SET: begin
              // Writing the value already held leaves dirty alone.
              if (addr_ok && cfg_rd_data != item.value) begin
                cfg_ctl.wr_en = 1'b1;
                dirty_next    = 1'b1;
              end
            end
            FN_TICK: begin
              tick_count_next = tick_count + 16'd1;
              case (io_mode)
                MODE_NOT_LOADED: begin
                  if (item.flash_state != FS_IDLE) begin
                    res.refused = 1'b1;
                  end else begin
                    io_mode_next  = MODE_LOADING;
                    res.flash_cmd = CMD_LOAD;
                  end
                end
                MODE_LOADED: begin
                  if (dirty && (tick_count & wb_mask) == 16'd0) begin
                    // Stamp the token, move to the next slot and emit it.
                    cfg_ctl.wr_en  = 1'b1;
                    cfg_wr_addr    = CIW'(TOKEN_POS);
                    cfg_wr_data    = MAGIC_TOKEN;
                    slot_next      = slot_wrap ? '0 : slot_inc[SPW-1:0];
                    run_cmd_next   = slot_wrap ? CMD_ERASE_WRITE : CMD_WRITE;
                    run_base_next  = slot_wrap ? 10'd0 : inc_base_full[9:0];
                    run_blank_next = 1'b0;
                    io_mode_next   = MODE_SAVING;
                    j_next         = '0;
                    state_next     = S_RUN_RD;
                    single         = 1'b0;
                  end
                end
                MODE_LOADING: begin
                  if (item.flash_state == FS_LOAD_ERR) begin
                    cfg_ctl.clear = 1'b1;
                    dirty_next    = 1'b0;
                    io_mode_next  = MODE_LOADED;
                    res.event_res = EV_CLEARED;
                  end else if (item.flash_state == FS_LOAD_DONE) begin
                    srch_base_next = LAST_BASE;
                    srch_slot_next = SPW'(NUM_SLOTS - 1);
                    state_next     = S_SRCH_RD;
                    single         = 1'b0;
                  end
                end
                MODE_SAVING: begin
                  if (item.flash_state == FS_SAVE_ERR) begin
                    io_mode_next = MODE_LOADED;
                  end else if (item.flash_state == FS_SAVE_DONE) begin
                    io_mode_next = MODE_LOADED;
                    dirty_next   = 1'b0;
                  end
                end
                MODE_ERASING: begin
                  if (item.flash_state == FS_SAVE_DONE ||
                      item.flash_state == FS_SAVE_ERR) begin
                    io_mode_next = MODE_LOADED;
                    dirty_next   = 1'b0;
                  end
                end
                default: begin
                end
              endcase
            end
            FN_WIPE: begin
              if (item.flash_state != FS_IDLE) begin
                res.refused = 1'b1;
              end else begin
                // The slot pointer stays; the run is blank words at offset 0.
                io_mode_next   = MODE_ERASING;
                run_cmd_next   = CMD_ERASE_WRITE;
                run_base_next  = 10'd0;
                run_blank_next = 1'b1;
                j_next         = '0;
                state_next     = S_RUN_RD;
                single         = 1'b0;
              end
            end
            FN_LOAD_WORD: begin
              sec_we = widx_ok;
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN_RD: begin
        cfg_ctl.rd_en = 1'b1;
        cfg_rd_addr   = j;
        state_next    = S_RUN_WR;
      end

      S_RUN_WR: begin
        // Words past the result cap are still buffered but not shown.
        if (!word_shown || out_free) begin
          sec_we    = 1'b1;
          sec_waddr = SAW'(j);
          sec_wdata = run_word;
          if (word_shown) begin
            emit                = 1'b1;
            res.flash_cmd       = run_cmd;
            res.flash_word_addr = run_base + 10'(j);
            res.data_word       = run_word;
            res.last            = (j == CIW'(RUN_EMIT - 1));
          end
          if (j == CIW'(NUM_ENTRIES - 1)) begin
            state_next = S_IDLE;
          end else begin
            j_next     = j + CIW'(1);
            state_next = S_RUN_RD;
          end
        end
      end

      S_SRCH_RD: begin
        sec_raddr  = srch_base + SAW'(TOKEN_POS);
        state_next = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (sec_rd == MAGIC_TOKEN) begin
          slot_next  = srch_slot;
          j_next     = '0;
          state_next = S_COPY_RD;
        end else if (srch_slot == '0) begin
          cfg_ctl.clear = 1'b1;
          dirty_next    = 1'b0;
          found_next    = 1'b0;
          state_next    = S_DONE;
        end else begin
          srch_slot_next = srch_slot - SPW'(1);
          srch_base_next = srch_base - SAW'(NUM_ENTRIES);
          state_next     = S_SRCH_RD;
        end
      end

      S_COPY_RD: begin
        sec_raddr  = srch_base + SAW'(j);
        state_next = S_COPY_WR;
      end

      S_COPY_WR: begin
        cfg_ctl.wr_en = 1'b1;
        cfg_wr_addr   = j;
        cfg_wr_data   = sec_rd;
        if (j == CIW'(NUM_ENTRIES - 1)) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else begin
          j_next     = j + CIW'(1);
          state_next = S_COPY_RD;
        end
      end

      S_DONE: begin
        if (out_free) begin
          io_mode_next  = MODE_LOADED;
          res.event_res = found ? EV_LOADED : EV_CLEARED;
          single        = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (single) begin
      emit       = 1'b1;
      res.last   = 1'b1;
      state_next = S_IDLE;
    end

    // Every result reports the mode and dirty flag as the word leaves them.
    res.store_state = io_mode_next;
    res.dirty_flag  = dirty_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      io_mode    <= MODE_NOT_LOADED;
      dirty      <= 1'b0;
      slot       <= '0;
      tick_count <= 16'd0;
      wb_mask    <= WB_MASK_RESET;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      io_mode    <= io_mode_next;
      dirty      <= dirty_next;
      slot       <= slot_next;
      tick_count <= tick_count_next;
      if (cfg_valid) begin
        wb_mask <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (emit) begin
      out_data <= res;
    end
    j         <= j_next;
    run_cmd   <= run_cmd_next;
    run_base  <= run_base_next;
    run_blank <= run_blank_next;
    srch_base <= srch_base_next;
    srch_slot <= srch_slot_next;
    found     <= found_next;
  end

  // The slot pointer never leaves the sector.
  `WLCS_ASSERT(a_slot_in_range, clk, rst, ({1'b0, slot} < (SPW+1)'(NUM_SLOTS)))
  // A set that changes a word leaves unsaved changes pending.
  `WLCS_ASSERT_NEXT(a_set_marks_dirty, clk, rst, (state == S_EXEC && item.func == FN_SET && cfg_ctl.wr_en), dirty)
  // A run only starts with the store saving or erasing.
  `WLCS_ASSERT_NEXT(a_run_mode, clk, rst, (state == S_EXEC && state_next == S_RUN_RD), (io_mode == MODE_SAVING || io_mode == MODE_ERASING))

endmodule

// ===== verif/wear_leveled_config_store_top_test.sv =====
// ---------------------------------------------------------------------------
// Wear-leveled configuration store testbench
// Drives get, set, tick, wipe and sector-load words into the store, predicts
// every result word from a behavioral copy of the store, and compares the
// results field by field while both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module wear_leveled_config_store_top_test;
  import wlcs_pkg::*;

  localparam int NUM_ENTRIES  = 32;
  localparam int SECTOR_WORDS = 1024;
  localparam int TOKEN_INDEX  = 31;
  localparam int TOKEN_POS    = (TOKEN_INDEX < NUM_ENTRIES) ? TOKEN_INDEX : NUM_ENTRIES - 1;
  localparam int NUM_SLOTS    = SECTOR_WORDS / NUM_ENTRIES;

  // Function codes the store does not use and flash states without meaning.
  localparam logic [2:0] FN_SPARE_A = 3'd5;
  localparam logic [2:0] FN_SPARE_B = 3'd6;
  localparam logic [2:0] FN_SPARE_C = 3'd7;
  localparam logic [2:0] FS_UNDEF_A = 3'd6;
  localparam logic [2:0] FS_UNDEF_B = 3'd7;

  // A load search is the slowest thing the store does after its last result
  // word: probe every slot, copy one, then report. Leave room for it.
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  wear_leveled_config_store_top #(
    .NUM_ENTRIES  (NUM_ENTRIES),
    .SECTOR_WORDS (SECTOR_WORDS),
    .TOKEN_INDEX  (TOKEN_INDEX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // -------------------------------------------------------------------------
  // Behavioral copy of the store. It advances once per accepted input word,
  // in acceptance order, and leaves the result words of that input word in
  // step_out. sector_seen marks sector words that were ever written, so the
  // stimulus can keep the load search away from words that hold nothing.
  // -------------------------------------------------------------------------
  logic [31:0] ram_copy    [NUM_ENTRIES];
  logic [31:0] sector_copy [SECTOR_WORDS];
  bit          sector_seen [SECTOR_WORDS];
  int          slot_copy;
  logic        dirty_copy;
  io_mode_t    mode_copy;
  logic [15:0] ticks_copy;
  logic [15:0] mask_copy;

  out_item_t   step_out[$];
  out_item_t   pending_results[$];
  in_item_t    fill_plan[$];

  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  function automatic void add_result(logic [31:0] rv, logic [1:0] cmd, logic [9:0] waddr,
                                     logic [31:0] data, logic [1:0] ev, logic refused);
    out_item_t r;
    if (step_out.size() >= RESULT_CAP) return;
    r = '0;
    r.read_value      = rv;
    r.flash_cmd       = cmd;
    r.flash_word_addr = waddr;
    r.data_word       = data;
    r.event_res       = ev;
    r.refused         = refused;
    step_out.push_back(r);
  endfunction

  // One run of NUM_ENTRIES words to flash; the run also lands in the low
  // words of the sector buffer.
  function automatic void emit_slot(logic [1:0] cmd, int base, bit blank);
    logic [31:0] wv;
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      wv = blank ? BLANK_WORD : ram_copy[j];
      sector_copy[j] = wv;
      sector_seen[j] = 1'b1;
      add_result('0, cmd, 10'(base + j), wv, EV_NONE, 1'b0);
    end
  endfunction

  // Every entry but the token entry goes back to all ones.
  function automatic void clear_ram();
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      if (j != TOKEN_POS) ram_copy[j] = BLANK_WORD;
    end
    dirty_copy = 1'b0;
  endfunction

  function automatic void compute_store_results(in_item_t w);
    bit         found;
    int         base;
    logic [1:0] cmd;
    step_out.delete();
    case (w.func)
      FN_GET: begin
        if (int'(w.addr) < NUM_ENTRIES) add_result(ram_copy[int'(w.addr)], CMD_NONE, '0, '0,
                                                   EV_NONE, 1'b0);
        else add_result('0, CMD_NONE, '0, '0, EV_NONE, 1'b0);
      end
      FN_SET: begin
        if (int'(w.addr) < NUM_ENTRIES) begin
          if (ram_copy[int'(w.addr)] != w.value) begin
            ram_copy[int'(w.addr)] = w.value;
            dirty_copy = 1'b1;
          end
        end
        add_result('0, CMD_NONE, '0, '0, EV_NONE, 1'b0);
      end
      FN_TICK: begin
        case (mode_copy)
          MODE_NOT_LOADED: begin
            if (w.flash_state != FS_IDLE) begin
              add_result('0, CMD_NONE, '0, '0, EV_NONE, 1'b1);
            end else begin
              mode_copy = MODE_LOADING;
              add_result('0, CMD_LOAD, '0, '0, EV_NONE, 1'b0);
            end
          end
          MODE_LOADED: begin
            if (dirty_copy && (ticks_copy & mask_copy) == 16'd0) begin
              ram_copy[TOKEN_POS] = MAGIC_TOKEN;
              slot_copy++;
              if (slot_copy >= NUM_SLOTS) begin
                slot_copy = 0;
                cmd = CMD_ERASE_WRITE;
                base = 0;
              end else begin
                cmd = CMD_WRITE;
                base = slot_copy * NUM_ENTRIES;
              end
              mode_copy = MODE_SAVING;
              emit_slot(cmd, base, 1'b0);
            end
          end
          MODE_LOADING: begin
            if (w.flash_state == FS_LOAD_ERR) begin
              clear_ram();
              mode_copy = MODE_LOADED;
              add_result('0, CMD_NONE, '0, '0, EV_CLEARED, 1'b0);
            end else if (w.flash_state == FS_LOAD_DONE) begin
              // The highest slot that carries the token wins.
              found = 1'b0;
              for (int s = NUM_SLOTS - 1; s >= 0 && !found; s--) begin
                base = s * NUM_ENTRIES;
                if (sector_copy[base + TOKEN_POS] == MAGIC_TOKEN) begin
                  for (int j = 0; j < NUM_ENTRIES; j++) ram_copy[j] = sector_copy[base + j];
                  slot_copy = s;
                  found = 1'b1;
                end
              end
              if (!found) clear_ram();
              mode_copy = MODE_LOADED;
              add_result('0, CMD_NONE, '0, '0, found ? EV_LOADED : EV_CLEARED, 1'b0);
            end
          end
          MODE_SAVING: begin
            if (w.flash_state == FS_SAVE_ERR) begin
              mode_copy = MODE_LOADED;
            end else if (w.flash_state == FS_SAVE_DONE) begin
              mode_copy = MODE_LOADED;
              dirty_copy = 1'b0;
            end
          end
          MODE_ERASING: begin
            if (w.flash_state == FS_SAVE_DONE || w.flash_state == FS_SAVE_ERR) begin
              mode_copy = MODE_LOADED;
              dirty_copy = 1'b0;
            end
          end
          default: begin
          end
        endcase
        ticks_copy = ticks_copy + 16'd1;
        if (step_out.size() == 0) add_result('0, CMD_NONE, '0, '0, EV_NONE, 1'b0);
      end
      FN_WIPE: begin
        if (w.flash_state != FS_IDLE) begin
          add_result('0, CMD_NONE, '0, '0, EV_NONE, 1'b1);
        end else begin
          mode_copy = MODE_ERASING;
          emit_slot(CMD_ERASE_WRITE, 0, 1'b1);
        end
      end
      FN_LOAD_WORD: begin
        if (int'(w.word_index) < SECTOR_WORDS) begin
          sector_copy[int'(w.word_index)] = w.value;
          sector_seen[int'(w.word_index)] = 1'b1;
        end
        add_result('0, CMD_NONE, '0, '0, EV_NONE, 1'b0);
      end
      default: add_result('0, CMD_NONE, '0, '0, EV_NONE, 1'b0);
    endcase
    // Status fields reflect the store after the whole input word.
    foreach (step_out[k]) begin
      step_out[k].last        = (k == step_out.size() - 1);
      step_out[k].store_state = mode_copy;
      step_out[k].dirty_flag  = dirty_copy;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers.
  // -------------------------------------------------------------------------
  function automatic in_item_t mk_word(logic [2:0] func, logic [7:0] addr, logic [31:0] value,
                                       logic [9:0] idx, logic [2:0] fs);
    in_item_t w;
    w.func        = func;
    w.addr        = addr;
    w.value       = value;
    w.word_index  = idx;
    w.flash_state = fs;
    return w;
  endfunction

  // A single status word as the store reports it for quick input words.
  function automatic out_item_t status_word(logic [31:0] rv, logic [1:0] cmd, logic [1:0] ev,
                                            logic refused, io_mode_t st, logic dt);
    out_item_t r;
    r = '0;
    r.read_value  = rv;
    r.flash_cmd   = cmd;
    r.event_res   = ev;
    r.refused     = refused;
    r.store_state = st;
    r.dirty_flag  = dt;
    r.last        = 1'b1;
    return r;
  endfunction

  // Any sector content except the token itself.
  function automatic logic [31:0] plain_value();
    logic [31:0] v;
    v = $urandom;
    if (v == MAGIC_TOKEN) v = v ^ 32'd1;
    return v;
  endfunction

  function automatic in_item_t sector_word(int idx, logic [31:0] value);
    return mk_word(FN_LOAD_WORD, 8'($urandom), value, 10'(idx), 3'($urandom));
  endfunction

  // Picks the next random input word from the current state of the copy.
  // While the store is loading, most words deliver a sector image that the
  // search can walk safely: the token position of every slot above the
  // chosen one holds a non-token word, and the chosen slot is complete.
  function automatic in_item_t draw_store_word();
    in_item_t w;
    int       pick;
    int       target;
    int       tok;
    int       q;
    bit       safe;
    bit       done;
    w = mk_word(FN_GET, 8'($urandom), $urandom, 10'($urandom), 3'($urandom));

    if (mode_copy == MODE_LOADING && fill_plan.size() == 0 && $urandom_range(99) < 30) begin
      if ($urandom_range(99) < 10) begin
        w.func = FN_TICK;
        w.flash_state = FS_LOAD_ERR;
        return w;
      end
      safe = 1'b1;
      done = 1'b0;
      for (int s = NUM_SLOTS - 1; s >= 0 && !done; s--) begin
        tok = s * NUM_ENTRIES + TOKEN_POS;
        if (!sector_seen[tok]) begin
          safe = 1'b0;
          done = 1'b1;
        end else if (sector_copy[tok] == MAGIC_TOKEN) begin
          for (int j = 0; j < NUM_ENTRIES; j++) begin
            if (!sector_seen[s * NUM_ENTRIES + j]) safe = 1'b0;
          end
          done = 1'b1;
        end
      end
      if (safe) begin
        w.func = FN_TICK;
        w.flash_state = FS_LOAD_DONE;
        return w;
      end
      // A target of -1 leaves the sector without any token.
      target = ($urandom_range(99) < 15) ? -1 : int'($urandom_range(NUM_SLOTS - 1));
      for (int s = NUM_SLOTS - 1; s > target; s--) begin
        tok = s * NUM_ENTRIES + TOKEN_POS;
        if (!sector_seen[tok] || sector_copy[tok] == MAGIC_TOKEN) begin
          fill_plan.push_back(sector_word(tok, plain_value()));
        end
      end
      if (target >= 0) begin
        for (int j = 0; j < NUM_ENTRIES; j++) begin
          q = $urandom_range(99);
          if (j == TOKEN_POS) fill_plan.push_back(sector_word(target * NUM_ENTRIES + j,
                                                              MAGIC_TOKEN));
          else if (q < 25) fill_plan.push_back(sector_word(target * NUM_ENTRIES + j,
                                                           BLANK_WORD));
          else if (q < 35) fill_plan.push_back(sector_word(target * NUM_ENTRIES + j, '0));
          else fill_plan.push_back(sector_word(target * NUM_ENTRIES + j, plain_value()));
        end
      end
    end

    if (fill_plan.size() > 0 && $urandom_range(99) < 85) return fill_plan.pop_front();

    pick = $urandom_range(99);
    if (pick < 25) begin
      w.func = FN_SET;
      if ($urandom_range(99) < 85) w.addr = 8'($urandom_range(NUM_ENTRIES - 1));
      q = $urandom_range(99);
      if (q < 20 && int'(w.addr) < NUM_ENTRIES) w.value = ram_copy[int'(w.addr)];
      else if (q < 35) w.value = ($urandom_range(1) == 0) ? BLANK_WORD : '0;
    end else if (pick < 40) begin
      w.func = FN_GET;
      if ($urandom_range(99) < 85) w.addr = 8'($urandom_range(NUM_ENTRIES - 1));
    end else if (pick < 75) begin
      w.func = FN_TICK;
      q = $urandom_range(99);
      case (mode_copy)
        MODE_LOADING: begin
          if (w.flash_state == FS_LOAD_DONE || w.flash_state == FS_LOAD_ERR) begin
            w.flash_state = FS_BUSY;
          end
        end
        MODE_SAVING, MODE_ERASING: begin
          if (q < 45) w.flash_state = FS_SAVE_DONE;
          else if (q < 70) w.flash_state = FS_SAVE_ERR;
        end
        default: begin
          if (q < 80) w.flash_state = FS_IDLE;
        end
      endcase
    end else if (pick < 82) begin
      // An accepted wipe would abandon a load, so only refused ones go in then.
      w.func = FN_WIPE;
      if (mode_copy == MODE_LOADING) w.flash_state = 3'($urandom_range(FS_UNDEF_B, FS_BUSY));
      else if ($urandom_range(99) < 75) w.flash_state = FS_IDLE;
    end else if (pick < 93) begin
      w.func = FN_LOAD_WORD;
      if (mode_copy == MODE_LOADING) w.value = plain_value();
      else if ($urandom_range(99) < 15) w.value = MAGIC_TOKEN;
    end else begin
      w.func = 3'($urandom_range(FN_SPARE_C, FN_SPARE_A));
    end
    return w;
  endfunction

  // -------------------------------------------------------------------------
  // Sender side. A word is offered at a falling edge and stays put until the
  // rising edge that accepts it; the copy advances at that same edge.
  // Callers are at a falling edge on entry and on return.
  // -------------------------------------------------------------------------
  task automatic offer(in_item_t w, bit typed, out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    compute_store_results(w);
    // A typed row takes the place of the predicted word but still advances
    // the copy, so the rows that follow are predicted from the right state.
    if (typed) pending_results.push_back(want);
    else foreach (step_out[k]) pending_results.push_back(step_out[k]);
    @(negedge clk);
  endtask

  // Waits for every expected word, then for the store to go quiet.
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic [15:0] mask);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    do @(posedge clk); while (!cfg_ready);
    mask_copy = mask;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(logic [15:0] mask, int send_pct, int recv_pct, int count,
                                  bit squeeze);
    write_mask(mask);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    // The receiver goes deaf for a long stretch while words keep coming, so
    // the store fills up and has to push back on its input.
    if (squeeze) hold_req++;
    repeat (count) offer(draw_store_word(), 1'b0, '0);
    in_valid <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Receiver side: random stalls, plus the long hold-off on request. The
  // hold-off is counted here so the sender never waits on it.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Result checking: every accepted result word is matched against the
  // oldest expected word, one field at a time.
  // -------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result word with nothing expected, expected none, got %h",
                 $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, out_data.read_value);
        check_field("flash_cmd", 32'(want.flash_cmd), 32'(out_data.flash_cmd));
        check_field("flash_word_addr", 32'(want.flash_word_addr),
                    32'(out_data.flash_word_addr));
        check_field("data_word", want.data_word, out_data.data_word);
        check_field("last", 32'(want.last), 32'(out_data.last));
        check_field("event_res", 32'(want.event_res), 32'(out_data.event_res));
        check_field("store_state", 32'(want.store_state), 32'(out_data.store_state));
        check_field("dirty_flag", 32'(want.dirty_flag), 32'(out_data.dirty_flag));
        check_field("refused", 32'(want.refused), 32'(out_data.refused));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Directed table. Rows whose result is plain from the reset state, an
  // extreme or a refusal carry it typed in; the rest go to the copy.
  // The table stops short of finishing the load: the store loads only once
  // after reset, and the random part delivers a sector image and searches it.
  // -------------------------------------------------------------------------
  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } vector_row_t;

  vector_row_t directed_rows[$];

  function automatic void add_row(in_item_t w, bit typed, out_item_t want);
    vector_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  initial begin
    // Reset state of the copy.
    foreach (ram_copy[j]) ram_copy[j] = BLANK_WORD;
    foreach (sector_copy[j]) begin
      sector_copy[j] = '0;
      sector_seen[j] = 1'b0;
    end
    slot_copy  = 0;
    dirty_copy = 1'b0;
    mode_copy  = MODE_NOT_LOADED;
    ticks_copy = '0;
    mask_copy  = WB_MASK_RESET;

    // Reads after reset, in range and out of range.
    add_row(mk_word(FN_GET, 8'd0, '0, '0, FS_IDLE), 1'b1,
            status_word(BLANK_WORD, CMD_NONE, EV_NONE, 1'b0, MODE_NOT_LOADED, 1'b0));
    add_row(mk_word(FN_GET, 8'hff, BLANK_WORD, 10'h3ff, FS_UNDEF_B), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b0, MODE_NOT_LOADED, 1'b0));
    add_row(mk_word(FN_GET, 8'(NUM_ENTRIES), '0, '0, FS_IDLE), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b0, MODE_NOT_LOADED, 1'b0));
    // Writing the value already held leaves the store clean; a new one dirties it.
    add_row(mk_word(FN_SET, 8'd0, BLANK_WORD, '0, FS_IDLE), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b0, MODE_NOT_LOADED, 1'b0));
    add_row(mk_word(FN_SET, 8'(TOKEN_POS), '0, '0, FS_IDLE), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b0, MODE_NOT_LOADED, 1'b1));
    add_row(mk_word(FN_SET, 8'hff, 32'h12345678, '0, FS_IDLE), 1'b0, '0);
    // Unused function codes only report status.
    add_row(mk_word(FN_SPARE_A, '0, '0, '0, FS_IDLE), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b0, MODE_NOT_LOADED, 1'b1));
    add_row(mk_word(FN_SPARE_C, 8'hff, BLANK_WORD, 10'h3ff, FS_UNDEF_B), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b0, MODE_NOT_LOADED, 1'b1));
    add_row(mk_word(FN_LOAD_WORD, '0, '0, 10'h3ff, FS_BUSY), 1'b0, '0);
    add_row(mk_word(FN_LOAD_WORD, 8'hff, BLANK_WORD, 10'd0, FS_IDLE), 1'b0, '0);
    // Load start and wipe are refused while the flash is not idle.
    add_row(mk_word(FN_TICK, '0, '0, '0, FS_BUSY), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b1, MODE_NOT_LOADED, 1'b1));
    add_row(mk_word(FN_TICK, '0, '0, '0, FS_UNDEF_A), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b1, MODE_NOT_LOADED, 1'b1));
    add_row(mk_word(FN_WIPE, '0, '0, '0, FS_BUSY), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b1, MODE_NOT_LOADED, 1'b1));
    add_row(mk_word(FN_WIPE, 8'h5a, 32'ha5a5a5a5, 10'h155, FS_SAVE_ERR), 1'b0, '0);
    // Load start, then flash states that mean nothing while loading.
    add_row(mk_word(FN_TICK, '0, '0, '0, FS_IDLE), 1'b1,
            status_word('0, CMD_LOAD, EV_NONE, 1'b0, MODE_LOADING, 1'b1));
    add_row(mk_word(FN_TICK, '0, '0, '0, FS_UNDEF_B), 1'b1,
            status_word('0, CMD_NONE, EV_NONE, 1'b0, MODE_LOADING, 1'b1));
    add_row(mk_word(FN_TICK, 8'hff, BLANK_WORD, 10'h3ff, FS_SAVE_DONE), 1'b0, '0);
    add_row(mk_word(FN_TICK, '0, '0, '0, FS_BUSY), 1'b0, '0);
    add_row(mk_word(FN_GET, 8'(TOKEN_POS), '0, '0, FS_IDLE), 1'b0, '0);
    add_row(mk_word(FN_SET, 8'(TOKEN_POS), MAGIC_TOKEN, '0, FS_IDLE), 1'b0, '0);
    add_row(mk_word(FN_SPARE_B, 8'h81, 32'h80000001, 10'h201, FS_LOAD_DONE), 1'b0, '0);
    add_row(mk_word(FN_GET, 8'd0, '0, '0, FS_IDLE), 1'b0, '0);

    // Every input is known from time zero; reset is held at the start.
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words run at full rate on both sides.
    foreach (directed_rows[i]) offer(directed_rows[i].word, directed_rows[i].typed,
                                     directed_rows[i].want);
    in_valid <= 1'b0;

    // Random phases. A zero mask lets every dirty tick write back, the full
    // mask almost never does. Idling moves from none to the sender, to the
    // receiver with the long hold-off, and to both at once.
    run_random_phase(16'h0000, 0, 0, 90, 1'b0);
    run_random_phase(16'hffff, 67, 0, 60, 1'b0);
    run_random_phase(16'h0001, 0, 67, 70, 1'b1);
    run_random_phase(16'($urandom_range(15)), 16, 16, 80, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
